[sv/ptue_pkg.sv]
// Shared constants for the page table update engine: opcodes, status codes,
// descriptor bits and table geometry. No dependencies.
`default_nettype none
package ptue_pkg;

    localparam int PTUE_NUM_TABLES     = 16;
    localparam int ENTRIES_PER_TABLE   = 512;
    localparam int IDX_W               = 9;
    localparam int PAGE_W              = 28;
    localparam int VPN_W               = 27;

    localparam logic [1:0] OP_MAP    = 2'd0;
    localparam logic [1:0] OP_UNMAP  = 2'd1;
    localparam logic [1:0] OP_REFLAG = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_L1_BLOCK   = 3'd1;
    localparam logic [2:0] ST_L2_BLOCK   = 3'd2;
    localparam logic [2:0] ST_NOT_MAPPED = 3'd3;
    localparam logic [2:0] ST_POOL_EMPTY = 3'd4;

    localparam int BIT_VALID = 0;
    localparam int BIT_TABLE = 1;
    localparam logic [63:0] DESC_TABLE = 64'h3;
    localparam logic [63:0] DESC_AF    = 64'h400;

endpackage
`default_nettype wire

[sv/page_table_update_engine_top.sv]
// Page table update engine top level: request sequencer around one table memory.
// Depends on ptue_pkg.
//
// A request beat is taken when start is high and busy is low; each request
// yields exactly one result beat on o_done, one cycle wide, which cannot be
// stalled. After reset the block first clears the whole table memory, one
// entry per cycle, and holds busy high meanwhile. A new request is not taken
// while one is in progress. The single-port-read table memory sets the rate.
// Unmap and reflag do three dependent reads, then the leaf write, or stop
// early when the walk fails. Map of an already linked page does two reads, a
// pool check and the leaf write; when it adds a level-3 table, or both tables,
// each table costs a clear of its 512 entries and a link write. A map that
// fails stops early. Unused opcodes finish without a walk.
`default_nettype none
module page_table_update_engine_top #(
    parameter int NUM_TABLES = ptue_pkg::PTUE_NUM_TABLES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ptue_pkg::PAGE_W-1:0] i_cfg_wdata,
    input  wire logic                        start,
    output      logic                        busy,
    input  wire logic [1:0]                  i_opcode,
    input  wire logic [38:0]                 i_virt_addr,
    input  wire logic [39:0]                 i_phys_addr,
    input  wire logic [63:0]                 i_attr_flags,
    output      logic                        o_done,
    output      logic [2:0]                  o_status,
    output      logic                        o_flush_valid,
    output      logic [ptue_pkg::VPN_W-1:0]  o_flush_page
);
    import ptue_pkg::*;

    localparam int TW    = $clog2(NUM_TABLES);
    localparam int NFW   = $clog2(NUM_TABLES + 1);
    localparam int AW    = TW + IDX_W;
    localparam int DEPTH = NUM_TABLES * ENTRIES_PER_TABLE;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_L1    = 4'd2;
    localparam logic [3:0] S_L2    = 4'd3;
    localparam logic [3:0] S_L3    = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_ALLOC = 4'd6;
    localparam logic [3:0] S_LINK  = 4'd7;
    localparam logic [3:0] S_LEAF  = 4'd8;

    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [63:0] mem_wdata;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [VPN_W-1:0]  r_vpn, n_vpn;
    logic [PAGE_W-1:0] r_pa, n_pa;
    logic [63:0]       r_flags, n_flags;
    logic [TW-1:0]     r_t2, n_t2, r_t3, n_t3;
    logic              r_have2, n_have2, r_have3, n_have3;
    logic [1:0]        r_need, n_need;
    logic [NFW-1:0]    r_next_free, n_next_free;
    logic [AW-1:0]     r_clr_cnt, n_clr_cnt;
    logic [IDX_W-1:0]  r_tcnt, n_tcnt;
    logic [PAGE_W-1:0] r_pool_base, n_pool_base;
    logic              r_done, n_done;
    logic [2:0]        r_status, n_status;
    logic              r_flush_valid, n_flush_valid;
    logic [VPN_W-1:0]  r_flush_page, n_flush_page;

    logic              fin;
    logic [2:0]        fin_status;
    logic [PAGE_W-1:0] off;
    logic              in_pool;
    logic [TW-1:0]     tsel;
    logic              e_valid, e_table;
    logic [NFW:0]      need_sum;
    logic [PAGE_W-1:0] desc_page;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_comb begin
        off       = r_rdata[39:12] - r_pool_base;
        in_pool   = off < PAGE_W'(NUM_TABLES);
        tsel      = off[TW-1:0];
        e_valid   = r_rdata[BIT_VALID];
        e_table   = r_rdata[BIT_TABLE];
        need_sum  = {1'b0, r_next_free} + (NFW+1)'(r_need);
        desc_page = r_pool_base + PAGE_W'(r_next_free);
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_vpn         = r_vpn;
        n_pa          = r_pa;
        n_flags       = r_flags;
        n_t2          = r_t2;
        n_t3          = r_t3;
        n_have2       = r_have2;
        n_have3       = r_have3;
        n_need        = r_need;
        n_next_free   = r_next_free;
        n_clr_cnt     = r_clr_cnt;
        n_tcnt        = r_tcnt;
        n_pool_base   = r_pool_base;
        n_done        = 1'b0;
        n_status      = r_status;
        n_flush_valid = r_flush_valid;
        n_flush_page  = r_flush_page;
        fin           = 1'b0;
        fin_status    = ST_OK;
        mem_we        = 1'b0;
        mem_waddr     = r_clr_cnt;
        mem_wdata     = '0;
        mem_raddr     = {r_t2, r_vpn[17:9]};

        if (i_cfg_we) begin
            n_pool_base = i_cfg_wdata;
        end

        unique case (r_state)
            S_CLR: begin
                mem_we    = 1'b1;
                n_clr_cnt = r_clr_cnt + AW'(1);
                if (r_clr_cnt == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_raddr = {TW'(0), i_virt_addr[38:30]};
                if (start) begin
                    n_op    = i_opcode;
                    n_vpn   = i_virt_addr[38:12];
                    n_pa    = i_phys_addr[39:12];
                    n_flags = i_attr_flags;
                    n_have2 = 1'b0;
                    n_have3 = 1'b0;
                    n_need  = 2'd0;
                    if (i_opcode == OP_MAP || i_opcode == OP_UNMAP ||
                        i_opcode == OP_REFLAG) begin
                        n_state = S_L1;
                    end else begin
                        n_done        = 1'b1;
                        n_status      = ST_OK;
                        n_flush_valid = 1'b0;
                        n_flush_page  = '0;
                    end
                end
            end
            S_L1: begin
                mem_raddr = {tsel, r_vpn[17:9]};
                if (r_op == OP_MAP) begin
                    if (!e_valid) begin
                        n_need  = 2'd2;
                        n_state = S_CHK;
                    end else if (!e_table) begin
                        fin        = 1'b1;
                        fin_status = ST_L1_BLOCK;
                    end else if (!in_pool) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_MAPPED;
                    end else begin
                        n_t2    = tsel;
                        n_have2 = 1'b1;
                        n_state = S_L2;
                    end
                end else if (!e_valid || !e_table || !in_pool) begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_MAPPED;
                end else begin
                    n_t2    = tsel;
                    n_state = S_L2;
                end
            end
            S_L2: begin
                mem_raddr = {tsel, r_vpn[8:0]};
                if (r_op == OP_MAP) begin
                    if (!e_valid) begin
                        n_need  = 2'd1;
                        n_state = S_CHK;
                    end else if (!e_table) begin
                        fin        = 1'b1;
                        fin_status = ST_L2_BLOCK;
                    end else if (!in_pool) begin
                        fin        = 1'b1;
                        fin_status = ST_NOT_MAPPED;
                    end else begin
                        n_t3    = tsel;
                        n_have3 = 1'b1;
                        n_state = S_CHK;
                    end
                end else if (!e_valid || !e_table || !in_pool) begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_MAPPED;
                end else begin
                    n_t3    = tsel;
                    n_state = S_L3;
                end
            end
            S_L3: begin
                if (!e_valid) begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_MAPPED;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_t3, r_vpn[8:0]};
                    if (r_op == OP_UNMAP) begin
                        mem_wdata = '0;
                    end else begin
                        mem_wdata = {24'd0, r_rdata[39:12], 12'd0}
                                    | DESC_TABLE | DESC_AF | r_flags;
                    end
                    fin        = 1'b1;
                    fin_status = ST_OK;
                end
            end
            S_CHK: begin
                if (r_next_free >= NFW'(NUM_TABLES) ||
                    need_sum > (NFW+1)'(NUM_TABLES)) begin
                    fin        = 1'b1;
                    fin_status = ST_POOL_EMPTY;
                end else if (!r_have2 || !r_have3) begin
                    n_tcnt  = '0;
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_ALLOC: begin
                mem_we    = 1'b1;
                mem_waddr = {r_next_free[TW-1:0], r_tcnt};
                mem_wdata = '0;
                n_tcnt    = r_tcnt + IDX_W'(1);
                if (r_tcnt == IDX_W'(ENTRIES_PER_TABLE - 1)) begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                mem_we      = 1'b1;
                mem_wdata   = {24'd0, desc_page, 12'd0} | DESC_TABLE;
                n_next_free = r_next_free + NFW'(1);
                if (!r_have2) begin
                    mem_waddr = {TW'(0), r_vpn[26:18]};
                    n_t2      = r_next_free[TW-1:0];
                    n_have2   = 1'b1;
                    n_tcnt    = '0;
                    n_state   = S_ALLOC;
                end else begin
                    mem_waddr = {r_t2, r_vpn[17:9]};
                    n_t3      = r_next_free[TW-1:0];
                    n_have3   = 1'b1;
                    n_state   = S_LEAF;
                end
            end
            S_LEAF: begin
                mem_we     = 1'b1;
                mem_waddr  = {r_t3, r_vpn[8:0]};
                mem_wdata  = {24'd0, r_pa, 12'd0} | DESC_TABLE | DESC_AF | r_flags;
                fin        = 1'b1;
                fin_status = ST_OK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_state       = S_IDLE;
            n_done        = 1'b1;
            n_status      = fin_status;
            n_flush_valid = (fin_status == ST_OK);
            n_flush_page  = (fin_status == ST_OK) ? r_vpn : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_next_free <= NFW'(1);
            r_pool_base <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_next_free <= n_next_free;
            r_pool_base <= n_pool_base;
            r_done      <= n_done;
        end
        r_op          <= n_op;
        r_vpn         <= n_vpn;
        r_pa          <= n_pa;
        r_flags       <= n_flags;
        r_t2          <= n_t2;
        r_t3          <= n_t3;
        r_have2       <= n_have2;
        r_have3       <= n_have3;
        r_need        <= n_need;
        r_tcnt        <= n_tcnt;
        r_status      <= n_status;
        r_flush_valid <= n_flush_valid;
        r_flush_page  <= n_flush_page;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_flush_valid = r_flush_valid;
    assign o_flush_page  = r_flush_page;

endmodule
`default_nettype wire
